FILE: rtl/log_timestamp_gap_detector_defines.svh
// Assertion macros used by the checker file of the gap detector.
`ifndef LOG_TIMESTAMP_GAP_DETECTOR_DEFINES_SVH
`define LOG_TIMESTAMP_GAP_DETECTOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LTGD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("log timestamp gap detector check failed");

// Consequent must hold in the cycle after the antecedent.
`define LTGD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("log timestamp gap detector check failed");

`endif

FILE: rtl/ltgd_pkg.sv
package ltgd_pkg;

    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 40;
    localparam int THRESH_W    = 40;
    localparam int LIMIT_W     = 16;
    localparam int LINE_NUM_W  = 32;
    localparam int DIFF_W      = 64;
    localparam int SECS_W      = 45;
    localparam int DAYSEC_W    = 26;
    localparam int HMS_W       = 19;
    localparam int YEAR_W      = 14;
    localparam int PAIR_W      = 7;
    localparam int DAYS_W      = 9;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 104;

    localparam logic [CFG_ADDR_W-1:0] REG_BRACKETED_MODE = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_OPEN_CHAR      = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_CLOSE_CHAR     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_GAP_THRESHOLD  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_MATCH_LIMIT    = 3'd4;

    localparam logic [7:0] OPEN_CHAR_RESET  = 8'd91;
    localparam logic [7:0] CLOSE_CHAR_RESET = 8'd93;

    localparam int STAMP_SPAN          = 19;
    localparam int STAMP_LEN_BARE      = 19;
    localparam int STAMP_LEN_BRACKETED = 21;
    localparam int DIGIT_COUNT         = 14;

    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_NINE = 8'h39;

    localparam logic [29:0] YEAR_SECS = 30'd977616000;
    localparam logic [16:0] DAY_SECS  = 17'd86400;
    localparam logic [11:0] HOUR_SECS = 12'd3600;
    localparam logic [5:0]  MIN_SECS  = 6'd60;

    typedef struct packed {
        logic              stamp;
        logic [YEAR_W-1:0] year;
        logic [3:0]        month_idx;
        logic [PAIR_W-1:0] day;
        logic [PAIR_W-1:0] hour;
        logic [PAIR_W-1:0] minute;
        logic [PAIR_W-1:0] second;
        logic              leap_year;
    } line_info_t;

    typedef struct packed {
        logic       hit;
        logic [3:0] slot;
    } slot_t;

    function automatic slot_t slot_of_offset(input logic [4:0] offset);
        slot_t s;
        s.hit  = 1'b1;
        s.slot = 4'd0;
        case (offset)
            5'd0:  s.slot = 4'd0;
            5'd1:  s.slot = 4'd1;
            5'd2:  s.slot = 4'd2;
            5'd3:  s.slot = 4'd3;
            5'd5:  s.slot = 4'd4;
            5'd6:  s.slot = 4'd5;
            5'd8:  s.slot = 4'd6;
            5'd9:  s.slot = 4'd7;
            5'd11: s.slot = 4'd8;
            5'd12: s.slot = 4'd9;
            5'd14: s.slot = 4'd10;
            5'd15: s.slot = 4'd11;
            5'd17: s.slot = 4'd12;
            5'd18: s.slot = 4'd13;
            default: s.hit = 1'b0;
        endcase
        return s;
    endfunction

    function automatic logic [DAYS_W-1:0] month_days(input logic [3:0] idx, input logic leap);
        logic [DAYS_W-1:0] d;
        case (idx)
            4'd0:  d = 9'd0;
            4'd1:  d = 9'd31;
            4'd2:  d = 9'd59;
            4'd3:  d = 9'd90;
            4'd4:  d = 9'd120;
            4'd5:  d = 9'd151;
            4'd6:  d = 9'd181;
            4'd7:  d = 9'd212;
            4'd8:  d = 9'd243;
            4'd9:  d = 9'd273;
            4'd10: d = 9'd304;
            4'd11: d = 9'd334;
            default: d = 9'd0;
        endcase
        if (leap && idx >= 4'd2 && idx <= 4'd11) begin
            d = d + 9'd1;
        end
        return d;
    endfunction

    function automatic logic [PAIR_W-1:0] digit_pair(input logic [3:0] hi, input logic [3:0] lo);
        return PAIR_W'(hi) * PAIR_W'(10) + PAIR_W'(lo);
    endfunction

endpackage

FILE: rtl/log_timestamp_gap_detector.sv
// Log timestamp gap detector. Log bytes arrive on the slave stream one request per byte, and a
// request with s_tlast high ends the current line; every line end gives one result request on
// the master stream, in order. A request is taken in every cycle in which the internal pipeline
// can move, so the sustained rate is one byte or line end per clock; a line end passes from the
// line snapshot at acceptance through the constant multiplies, the seconds sum, and the
// difference and threshold compare into the result register. Once the number of gaps found
// reaches a non-zero match limit, the block keeps taking requests but gives no more results
// until reset.
module log_timestamp_gap_detector #(
    parameter int MAX_LINE_BYTES = 2048
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [ltgd_pkg::IN_TDATA_W-1:0]     s_tdata,   // [7:0] char_byte
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [31:0] line_number, [32] has_stamp, [33] gap_found, [97:34] gap_seconds,
    // [98] limit_reached, [103:99] zero
    output logic [ltgd_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  logic                                cfg_wr_en,
    input  logic [ltgd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [ltgd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int LW = ltgd_pkg::LINE_NUM_W;
    localparam int SW = ltgd_pkg::SECS_W;
    localparam int DW = ltgd_pkg::DIFF_W;

    // Configuration registers.
    logic                          bracketed_reg;
    logic [7:0]                    open_char_reg;
    logic [7:0]                    close_char_reg;
    logic [ltgd_pkg::THRESH_W-1:0] threshold_reg;
    logic [ltgd_pkg::LIMIT_W-1:0]  limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bracketed_reg  <= 1'b1;
            open_char_reg  <= ltgd_pkg::OPEN_CHAR_RESET;
            close_char_reg <= ltgd_pkg::CLOSE_CHAR_RESET;
            threshold_reg  <= '0;
            limit_reg      <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                ltgd_pkg::REG_BRACKETED_MODE: bracketed_reg  <= cfg_wdata[0];
                ltgd_pkg::REG_OPEN_CHAR:      open_char_reg  <= cfg_wdata[7:0];
                ltgd_pkg::REG_CLOSE_CHAR:     close_char_reg <= cfg_wdata[7:0];
                ltgd_pkg::REG_GAP_THRESHOLD:  threshold_reg  <= cfg_wdata[ltgd_pkg::THRESH_W-1:0];
                ltgd_pkg::REG_MATCH_LIMIT:    limit_reg      <= cfg_wdata[ltgd_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline control.
    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic s3_valid_reg, s3_valid_next;
    logic out_valid_reg, out_valid_next;
    logic stopped_reg, stopped_next;
    logic s1_ready, s2_ready, s3_ready;
    logic in_fire, end_fire, byte_fire, out_load, stop_now;

    assign s3_ready  = !out_valid_reg || m_tready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign s_tready  = stopped_reg || s1_ready;
    assign in_fire   = s_tvalid && s_tready && !stopped_reg;
    assign end_fire  = in_fire && s_tlast;
    assign byte_fire = in_fire && !s_tlast;
    assign out_load  = s3_valid_reg && s3_ready;

    ltgd_pkg::line_info_t line_info;

    ltgd_line_capture #(
        .MAX_LINE_BYTES (MAX_LINE_BYTES)
    ) u_capture (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .byte_en        (byte_fire),
        .line_done      (end_fire),
        .char_byte      (s_tdata[7:0]),
        .bracketed_mode (bracketed_reg),
        .open_char      (open_char_reg),
        .close_char     (close_char_reg),
        .line_info      (line_info)
    );

    // Stage 1: line snapshot.
    logic [LW-1:0]        line_cnt_reg, line_cnt_next;
    logic [LW-1:0]        s1_line_reg;
    ltgd_pkg::line_info_t s1_info_reg;

    always_comb begin
        line_cnt_next = line_cnt_reg;
        if (end_fire) begin
            line_cnt_next = (line_cnt_reg == '1) ? LW'(1) : line_cnt_reg + LW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (end_fire) begin
            s1_line_reg <= line_cnt_reg;
            s1_info_reg <= line_info;
        end
    end

    // Stage 2: constant multiplies.
    logic [LW-1:0]                 s2_line_reg;
    logic                          s2_stamp_reg, s2_leap_reg;
    logic [SW-1:0]                 s2_year_secs_reg;
    logic [ltgd_pkg::DAYSEC_W-1:0] s2_day_common_reg, s2_day_leap_reg;
    logic [ltgd_pkg::HMS_W-1:0]    s2_hms_reg;
    logic [ltgd_pkg::DAYS_W-1:0]   days_common, days_leap;

    assign days_common = ltgd_pkg::month_days(s1_info_reg.month_idx, 1'b0)
                         + ltgd_pkg::DAYS_W'(s1_info_reg.day);
    assign days_leap   = ltgd_pkg::month_days(s1_info_reg.month_idx, 1'b1)
                         + ltgd_pkg::DAYS_W'(s1_info_reg.day);

    always_ff @(posedge aclk) begin
        if (s2_ready) begin
            s2_line_reg       <= s1_line_reg;
            s2_stamp_reg      <= s1_info_reg.stamp;
            s2_leap_reg       <= s1_info_reg.leap_year;
            s2_year_secs_reg  <= SW'(s1_info_reg.year) * SW'(ltgd_pkg::YEAR_SECS);
            s2_day_common_reg <= ltgd_pkg::DAYSEC_W'(days_common)
                                 * ltgd_pkg::DAYSEC_W'(ltgd_pkg::DAY_SECS);
            s2_day_leap_reg   <= ltgd_pkg::DAYSEC_W'(days_leap)
                                 * ltgd_pkg::DAYSEC_W'(ltgd_pkg::DAY_SECS);
            s2_hms_reg        <= ltgd_pkg::HMS_W'(s1_info_reg.hour)
                                 * ltgd_pkg::HMS_W'(ltgd_pkg::HOUR_SECS)
                                 + ltgd_pkg::HMS_W'(s1_info_reg.minute)
                                 * ltgd_pkg::HMS_W'(ltgd_pkg::MIN_SECS)
                                 + ltgd_pkg::HMS_W'(s1_info_reg.second);
        end
    end

    // Stage 3: seconds for both leap choices.
    logic [LW-1:0] s3_line_reg;
    logic          s3_stamp_reg, s3_leap_reg;
    logic [SW-1:0] s3_now_common_reg, s3_now_leap_reg;

    always_ff @(posedge aclk) begin
        if (s3_ready) begin
            s3_line_reg       <= s2_line_reg;
            s3_stamp_reg      <= s2_stamp_reg;
            s3_leap_reg       <= s2_leap_reg;
            s3_now_common_reg <= s2_year_secs_reg + SW'(s2_day_common_reg) + SW'(s2_hms_reg);
            s3_now_leap_reg   <= s2_year_secs_reg + SW'(s2_day_leap_reg) + SW'(s2_hms_reg);
        end
    end

    // Final stage: the leap latch, previous stamp and gap count are updated in line order here.
    logic                         year_latched_reg, year_latched_next;
    logic                         leap_flag_reg, leap_flag_next;
    logic [DW-1:0]                prev_secs_reg, prev_secs_next;
    logic                         prev_valid_reg, prev_valid_next;
    logic [ltgd_pkg::LIMIT_W-1:0] gaps_reg, gaps_next;
    logic                         leap_sel;
    logic [DW-1:0]                now_secs, diff_raw, diff_out;
    logic [ltgd_pkg::LIMIT_W-1:0] gaps_after;
    logic                         gap, hit;

    assign leap_sel = year_latched_reg ? leap_flag_reg : s3_leap_reg;
    assign now_secs = DW'(leap_sel ? s3_now_leap_reg : s3_now_common_reg);
    assign diff_raw = now_secs - prev_secs_reg;
    assign gap      = s3_stamp_reg && prev_valid_reg && (diff_raw >= DW'(threshold_reg));
    assign diff_out = (s3_stamp_reg && prev_valid_reg) ? diff_raw : '0;
    assign gaps_after = (gap && gaps_reg != '1) ? gaps_reg + ltgd_pkg::LIMIT_W'(1) : gaps_reg;
    assign hit      = gap && (limit_reg != '0) && (gaps_after >= limit_reg);
    assign stop_now = out_load && hit;

    always_comb begin
        year_latched_next = year_latched_reg;
        leap_flag_next    = leap_flag_reg;
        prev_secs_next    = prev_secs_reg;
        prev_valid_next   = prev_valid_reg;
        gaps_next         = gaps_reg;
        stopped_next      = stopped_reg || stop_now;
        if (out_load && s3_stamp_reg) begin
            year_latched_next = 1'b1;
            leap_flag_next    = leap_sel;
            prev_secs_next    = now_secs;
            prev_valid_next   = 1'b1;
            gaps_next         = gaps_after;
        end
    end

    // A stop discards every line end queued behind the one that reached the limit.
    always_comb begin
        s1_valid_next  = end_fire ? 1'b1 : (s2_ready ? 1'b0 : s1_valid_reg);
        s2_valid_next  = s2_ready ? s1_valid_reg : s2_valid_reg;
        s3_valid_next  = s3_ready ? s2_valid_reg : s3_valid_reg;
        out_valid_next = s3_ready ? s3_valid_reg : out_valid_reg;
        if (stop_now) begin
            s1_valid_next = 1'b0;
            s2_valid_next = 1'b0;
            s3_valid_next = 1'b0;
        end
    end

    logic [LW-1:0] out_line_reg;
    logic          out_stamp_reg, out_gap_reg, out_hit_reg;
    logic [DW-1:0] out_diff_reg;

    always_ff @(posedge aclk) begin
        if (s3_ready) begin
            out_line_reg  <= s3_line_reg;
            out_stamp_reg <= s3_stamp_reg;
            out_gap_reg   <= gap;
            out_diff_reg  <= diff_out;
            out_hit_reg   <= hit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            stopped_reg      <= 1'b0;
            line_cnt_reg     <= LW'(1);
            year_latched_reg <= 1'b0;
            leap_flag_reg    <= 1'b0;
            prev_secs_reg    <= '0;
            prev_valid_reg   <= 1'b0;
            gaps_reg         <= '0;
        end else begin
            s1_valid_reg     <= s1_valid_next;
            s2_valid_reg     <= s2_valid_next;
            s3_valid_reg     <= s3_valid_next;
            out_valid_reg    <= out_valid_next;
            stopped_reg      <= stopped_next;
            line_cnt_reg     <= line_cnt_next;
            year_latched_reg <= year_latched_next;
            leap_flag_reg    <= leap_flag_next;
            prev_secs_reg    <= prev_secs_next;
            prev_valid_reg   <= prev_valid_next;
            gaps_reg         <= gaps_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_hit_reg, out_diff_reg, out_gap_reg, out_stamp_reg, out_line_reg};

endmodule

FILE: rtl/ltgd_line_capture.sv
module ltgd_line_capture #(
    parameter int MAX_LINE_BYTES = 2048
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  byte_en,
    input  logic                  line_done,
    input  logic [7:0]            char_byte,
    input  logic                  bracketed_mode,
    input  logic [7:0]            open_char,
    input  logic [7:0]            close_char,
    output ltgd_pkg::line_info_t  line_info
);

    localparam int POS_W = $clog2(MAX_LINE_BYTES);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       first_byte_reg, first_byte_next;
    logic             close_seen_reg, close_seen_next;
    logic             digits_bad_reg, digits_bad_next;
    logic [3:0]       digit_reg [ltgd_pkg::DIGIT_COUNT];
    logic [3:0]       digit_next [ltgd_pkg::DIGIT_COUNT];

    logic [POS_W-1:0] start;
    logic [POS_W-1:0] offset;
    logic             in_span;
    logic             pos_full;
    logic             is_digit;
    ltgd_pkg::slot_t  slot;

    assign start    = bracketed_mode ? POS_W'(1) : POS_W'(0);
    assign offset   = pos_reg - start;
    assign in_span  = (pos_reg >= start) && (offset < POS_W'(ltgd_pkg::STAMP_SPAN));
    assign pos_full = (pos_reg == POS_W'(MAX_LINE_BYTES - 1));
    assign is_digit = (char_byte >= ltgd_pkg::ASCII_ZERO) && (char_byte <= ltgd_pkg::ASCII_NINE);
    assign slot     = ltgd_pkg::slot_of_offset(offset[4:0]);

    always_comb begin
        pos_next        = pos_reg;
        first_byte_next = first_byte_reg;
        close_seen_next = close_seen_reg;
        digits_bad_next = digits_bad_reg;
        digit_next      = digit_reg;
        if (line_done) begin
            pos_next        = '0;
            first_byte_next = '0;
            close_seen_next = 1'b0;
            digits_bad_next = 1'b0;
            for (int i = 0; i < ltgd_pkg::DIGIT_COUNT; i++) begin
                digit_next[i] = '0;
            end
        end else if (byte_en && !pos_full) begin
            if (pos_reg == '0) begin
                first_byte_next = char_byte;
            end
            if (pos_reg != '0 && char_byte == close_char) begin
                close_seen_next = 1'b1;
            end
            if (in_span && slot.hit) begin
                if (is_digit) begin
                    digit_next[slot.slot] = 4'(char_byte - ltgd_pkg::ASCII_ZERO);
                end else begin
                    digits_bad_next = 1'b1;
                end
            end
            pos_next = pos_reg + POS_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg        <= '0;
            first_byte_reg <= '0;
            close_seen_reg <= 1'b0;
            digits_bad_reg <= 1'b0;
            for (int i = 0; i < ltgd_pkg::DIGIT_COUNT; i++) begin
                digit_reg[i] <= '0;
            end
        end else begin
            pos_reg        <= pos_next;
            first_byte_reg <= first_byte_next;
            close_seen_reg <= close_seen_next;
            digits_bad_reg <= digits_bad_next;
            digit_reg      <= digit_next;
        end
    end

    logic [ltgd_pkg::PAIR_W-1:0] century, year_lo, month;
    logic                        len_ok, month_ok;

    assign century = ltgd_pkg::digit_pair(digit_reg[0], digit_reg[1]);
    assign year_lo = ltgd_pkg::digit_pair(digit_reg[2], digit_reg[3]);
    assign month   = ltgd_pkg::digit_pair(digit_reg[4], digit_reg[5]);

    assign len_ok = bracketed_mode
        ? (pos_reg >= POS_W'(ltgd_pkg::STAMP_LEN_BRACKETED)) && (first_byte_reg == open_char)
          && close_seen_reg
        : (pos_reg >= POS_W'(ltgd_pkg::STAMP_LEN_BARE));
    assign month_ok = (month >= ltgd_pkg::PAIR_W'(1)) && (month <= ltgd_pkg::PAIR_W'(12));

    always_comb begin
        line_info.stamp     = len_ok && !digits_bad_reg && month_ok;
        line_info.year      = ltgd_pkg::YEAR_W'(century) * ltgd_pkg::YEAR_W'(100)
                              + ltgd_pkg::YEAR_W'(year_lo);
        line_info.month_idx = 4'(month - ltgd_pkg::PAIR_W'(1));
        line_info.day       = ltgd_pkg::digit_pair(digit_reg[6], digit_reg[7]);
        line_info.hour      = ltgd_pkg::digit_pair(digit_reg[8], digit_reg[9]);
        line_info.minute    = ltgd_pkg::digit_pair(digit_reg[10], digit_reg[11]);
        line_info.second    = ltgd_pkg::digit_pair(digit_reg[12], digit_reg[13]);
        // Divisible by 4, and either not a century year or a century divisible by 400.
        line_info.leap_year = (line_info.year[1:0] == 2'b00)
                              && ((year_lo != '0) || (century[1:0] == 2'b00));
    end

endmodule

FILE: rtl/ltgd_checker.sv
`include "log_timestamp_gap_detector_defines.svh"

module ltgd_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [ltgd_pkg::OUT_TDATA_W-1:0] m_tdata
);

    localparam int BIT_STAMP = 32;
    localparam int BIT_GAP   = 33;
    localparam int BIT_HIT   = 98;

    logic          has_stamp, gap_found, limit_hit;
    logic [63:0]   gap_seconds;

    assign has_stamp   = m_tdata[BIT_STAMP];
    assign gap_found   = m_tdata[BIT_GAP];
    assign limit_hit   = m_tdata[BIT_HIT];
    assign gap_seconds = m_tdata[97:34];

    `LTGD_ASSERT_NEXT(a_result_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `LTGD_ASSERT_SAME(a_gap_needs_stamp, m_tvalid && gap_found, has_stamp)
    `LTGD_ASSERT_SAME(a_limit_needs_gap, m_tvalid && limit_hit, gap_found)
    `LTGD_ASSERT_SAME(a_no_stamp_no_diff, m_tvalid && !has_stamp, gap_seconds == 64'd0)
    `LTGD_ASSERT_NEXT(a_quiet_after_stop, m_tvalid && m_tready && limit_hit, !m_tvalid)

endmodule

bind log_timestamp_gap_detector ltgd_checker u_ltgd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
